// File: hw/rtl/srr_pkg.sv
// Shared types, constants and helpers of the selective-repeat reorder block.
package srr_pkg;

   // Default number of reorder slots
   localparam int WINDOW_DEF  = 16;
   // Largest byte count a segment may carry; larger counts are clamped
   localparam int MAX_PAYLOAD = 1024;

   localparam int INDEX_W = 32;
   localparam int COUNT_W = 11;
   localparam int TAG_W   = 16;
   localparam int BYTES_W = 32;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 64;

   // Result kinds
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HEAD,
      ST_DLV,
      ST_ACK
   } state_type;

   // One buffered early segment
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TAG_W-1:0]   tag;
   } slot_entry_type;

   // One result transaction
   typedef struct packed {
      logic               kind;
      logic [TAG_W-1:0]   out_tag;
      logic [COUNT_W-1:0] out_count;
      logic [INDEX_W-1:0] ack_index;
      logic               dropped;
      logic               done_res;
      logic               last;
   } rsp_item_type;

   // Add a segment's bytes to the running total, saturating at all ones
   function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] acc,
                                                  input logic [COUNT_W-1:0] n);
      logic [BYTES_W:0] sum;
      sum = {1'b0, acc} + (BYTES_W+1)'(n);
      return sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
   endfunction

endpackage

// File: hw/rtl/srr_slot_mem.sv
// Reorder slot memory: one write port, one registered read port.
module srr_slot_mem #(
   parameter int WINDOW = srr_pkg::WINDOW_DEF,
   parameter int SW     = $clog2(WINDOW)
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [SW-1:0]          wr_addr,
   input  srr_pkg::slot_entry_type wr_data,
   input  logic [SW-1:0]          rd_addr,
   output srr_pkg::slot_entry_type rd_data
);
   import srr_pkg::*;

   slot_entry_type slot_ram [WINDOW];
   slot_entry_type rd_data_ff;

   // Store an early segment
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ram[wr_addr] <= wr_data;
      end
   end

   // Registered read: data for an address arrives in the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_ram[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/srr_rsp_reg.sv
// Result output register: holds one transaction until the consumer takes it.
module srr_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  srr_pkg::rsp_item_type item,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output srr_pkg::rsp_item_type rsp_item
);
   import srr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   rsp_item_type item_in;

   // Free when empty or when the held transaction leaves this cycle
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = item;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

// File: hw/rtl/srr_ctrl.sv
// Reorder controller: window bookkeeping, slot scan and result sequencing.
module srr_ctrl #(
   parameter int WINDOW = srr_pkg::WINDOW_DEF,
   parameter int SW     = $clog2(WINDOW)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srr_pkg::INDEX_W-1:0]    seg_index,
   input  logic [srr_pkg::COUNT_W-1:0]    byte_count,
   input  logic [srr_pkg::TAG_W-1:0]      payload_tag,
   input  logic [srr_pkg::BYTES_W-1:0]    total_bytes,
   output logic                           mem_wr_en,
   output logic [SW-1:0]                  mem_wr_addr,
   output srr_pkg::slot_entry_type        mem_wr_data,
   output logic [SW-1:0]                  mem_rd_addr,
   input  srr_pkg::slot_entry_type        mem_rd_data,
   input  logic                           out_free,
   output logic                           out_load,
   output srr_pkg::rsp_item_type          out_item
);
   import srr_pkg::*;

   localparam int RW = $clog2(WINDOW + 1);

   state_type             state_ff, state_in;
   logic [INDEX_W-1:0]    exp_ff, exp_in;
   logic [BYTES_W-1:0]    acc_ff, acc_in;
   logic [SW-1:0]         exp_slot_ff, exp_slot_in;
   logic [WINDOW-1:0]     valid_ff, valid_in;
   logic [SW-1:0]         scan_ptr_ff, scan_ptr_in;
   logic [SW-1:0]         dlv_ptr_ff, dlv_ptr_in;
   logic [RW-1:0]         run_ff, run_in;
   logic [RW-1:0]         left_ff, left_in;
   logic                  pend_ff, pend_in;
   logic                  drop_ff, drop_in;
   logic [COUNT_W-1:0]    head_count_ff, head_count_in;
   logic [TAG_W-1:0]      head_tag_ff, head_tag_in;
   logic [SW-1:0]         rd_addr_q_ff;

   logic [COUNT_W-1:0]    cnt_clamp;
   logic [INDEX_W-1:0]    offset;
   logic                  seg_old;
   logic                  in_window;
   logic [SW:0]           slot_sum;
   logic [SW-1:0]         store_slot;
   logic                  done_now;

   // Step a slot pointer around the window
   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] p);
      return (p == SW'(WINDOW - 1)) ? '0 : p + 1'b1;
   endfunction

   // Classify the offered segment against the window
   assign cnt_clamp  = (32'(byte_count) > 32'(MAX_PAYLOAD)) ? COUNT_W'(MAX_PAYLOAD)
                                                           : byte_count;
   assign seg_old    = seg_index < exp_ff;
   assign offset     = seg_index - exp_ff;
   assign in_window  = offset < 32'(WINDOW);
   assign slot_sum   = {1'b0, exp_slot_ff} + {1'b0, offset[SW-1:0]};
   assign store_slot = (slot_sum >= (SW+1)'(WINDOW)) ? SW'(slot_sum - (SW+1)'(WINDOW))
                                                      : slot_sum[SW-1:0];
   assign done_now   = acc_ff >= total_bytes;

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      acc_in        = acc_ff;
      exp_slot_in   = exp_slot_ff;
      valid_in      = valid_ff;
      scan_ptr_in   = scan_ptr_ff;
      dlv_ptr_in    = dlv_ptr_ff;
      run_in        = run_ff;
      left_in       = left_ff;
      pend_in       = 1'b0;
      drop_in       = drop_ff;
      head_count_in = head_count_ff;
      head_tag_in   = head_tag_ff;

      req_tready    = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = store_slot;
      mem_wr_data   = '{count: cnt_clamp, tag: payload_tag};
      mem_rd_addr   = dlv_ptr_ff;
      out_load      = 1'b0;
      out_item      = '{kind: KIND_DELIVER, out_tag: '0, out_count: '0,
                        ack_index: exp_ff, dropped: 1'b0, done_res: done_now,
                        last: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && !seg_old) begin
               drop_in = 1'b0;
               if (offset == '0) begin
                  // In-order: take its bytes, then look for buffered successors
                  head_count_in = cnt_clamp;
                  head_tag_in   = payload_tag;
                  acc_in        = sat_add(acc_ff, cnt_clamp);
                  exp_in        = exp_ff + 1'b1;
                  scan_ptr_in   = slot_inc(exp_slot_ff);
                  dlv_ptr_in    = slot_inc(exp_slot_ff);
                  run_in        = '0;
                  state_in      = ST_SCAN;
               end else if (in_window) begin
                  // Early: store or overwrite its slot
                  mem_wr_en             = 1'b1;
                  valid_in[store_slot]  = 1'b1;
                  state_in              = ST_ACK;
               end else begin
                  drop_in  = 1'b1;
                  state_in = ST_ACK;
               end
            end
         end

         ST_SCAN: begin
            // First pass: count the run and sum its bytes
            mem_rd_addr = scan_ptr_ff;
            if (pend_ff) begin
               acc_in = sat_add(acc_ff, mem_rd_data.count);
            end
            if (valid_ff[scan_ptr_ff] && (run_ff != RW'(WINDOW))) begin
               valid_in[scan_ptr_ff] = 1'b0;
               pend_in     = 1'b1;
               scan_ptr_in = slot_inc(scan_ptr_ff);
               run_in      = run_ff + 1'b1;
               exp_in      = exp_ff + 1'b1;
            end else begin
               exp_slot_in = scan_ptr_ff;
               left_in     = run_ff;
               state_in    = ST_HEAD;
            end
         end

         ST_HEAD: begin
            // Deliver the segment that arrived in order
            if (out_free) begin
               out_load           = 1'b1;
               out_item.out_tag   = head_tag_ff;
               out_item.out_count = head_count_ff;
               state_in           = (left_ff == '0) ? ST_ACK : ST_DLV;
            end
         end

         ST_DLV: begin
            // Second pass: release buffered successors in order
            if (out_free && (rd_addr_q_ff == dlv_ptr_ff)) begin
               out_load           = 1'b1;
               out_item.out_tag   = mem_rd_data.tag;
               out_item.out_count = mem_rd_data.count;
               mem_rd_addr        = slot_inc(dlv_ptr_ff);
               dlv_ptr_in         = slot_inc(dlv_ptr_ff);
               left_in            = left_ff - 1'b1;
               if (left_ff == RW'(1)) begin
                  state_in = ST_ACK;
               end
            end
         end

         ST_ACK: begin
            // Close the segment with a cumulative acknowledgment
            if (out_free) begin
               out_load         = 1'b1;
               out_item.kind    = KIND_ACK;
               out_item.dropped = drop_ff;
               out_item.last    = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         exp_ff      <= '0;
         acc_ff      <= '0;
         exp_slot_ff <= '0;
         valid_ff    <= '0;
         scan_ptr_ff <= '0;
         dlv_ptr_ff  <= '0;
         run_ff      <= '0;
         left_ff     <= '0;
         pend_ff     <= 1'b0;
         drop_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         exp_ff      <= exp_in;
         acc_ff      <= acc_in;
         exp_slot_ff <= exp_slot_in;
         valid_ff    <= valid_in;
         scan_ptr_ff <= scan_ptr_in;
         dlv_ptr_ff  <= dlv_ptr_in;
         run_ff      <= run_in;
         left_ff     <= left_in;
         pend_ff     <= pend_in;
         drop_ff     <= drop_in;
      end
   end

   // Head segment fields and the address behind the read data
   always_ff @(posedge clock) begin
      head_count_ff <= head_count_in;
      head_tag_ff   <= head_tag_in;
      rd_addr_q_ff  <= mem_rd_addr;
   end

endmodule

// File: hw/rtl/selective_repeat_reorder.sv
// Top level of the selective-repeat reorder block.
//
// Receives segment descriptors and restores sequence order through a window of
// WINDOW slots held in a single-port-write, registered-read slot memory. A
// segment older than the next expected index produces nothing; one stored
// early or dropped beyond the window yields one acknowledgment. An in-order
// segment that releases buffered successors takes two passes: one over the
// slot memory sums the run's bytes so every result can carry the final index
// and done flag, and a second reads the slots again to deliver them. Output
// backpressure stalls the results. A new segment is taken while the last result
// still waits in the output register. The user writes total_bytes through the
// csr port only while the block idles; the block itself does not enforce this.
module selective_repeat_reorder #(
   parameter int WINDOW = srr_pkg::WINDOW_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // seg_index[31:0], byte_count[42:32], payload_tag[58:43], zero fill
   input  logic [srr_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_tag[15:0], out_count[26:16], ack_index[58:27], dropped[59],
   // done_res[60], zero fill
   output logic [srr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [srr_pkg::BYTES_W-1:0]        csr_data
);
   import srr_pkg::*;

   localparam int SW = $clog2(WINDOW);

   logic [BYTES_W-1:0] total_ff;
   logic [BYTES_W-1:0] total_in;

   logic               mem_wr_en;
   logic [SW-1:0]      mem_wr_addr;
   slot_entry_type     mem_wr_data;
   logic [SW-1:0]      mem_rd_addr;
   slot_entry_type     mem_rd_data;
   logic               out_free;
   logic               out_load;
   rsp_item_type       out_item;
   rsp_item_type       rsp_item;

   // Hold the configured transfer size
   assign csr_ready = 1'b1;
   assign total_in  = (csr_valid && csr_ready) ? csr_data : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   srr_ctrl #(
      .WINDOW (WINDOW),
      .SW     (SW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .seg_index   (req_tdata[31:0]),
      .byte_count  (req_tdata[42:32]),
      .payload_tag (req_tdata[58:43]),
      .total_bytes (total_ff),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_item    (out_item)
   );

   srr_slot_mem #(
      .WINDOW (WINDOW),
      .SW     (SW)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   srr_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .item       (out_item),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result transaction
   assign rsp_tdata = {3'b000, rsp_item.done_res, rsp_item.dropped, rsp_item.ack_index,
                       rsp_item.out_count, rsp_item.out_tag};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

endmodule

// File: tb/tb_selective_repeat_reorder.sv
// Self-checking testbench of the selective-repeat reorder block: stream driver, predictor, monitor.
`timescale 1ns / 100ps

module tb_selective_repeat_reorder;
   import srr_pkg::*;

   localparam int SLOTS = WINDOW_DEF;

   typedef struct {
      logic [INDEX_W-1:0] seg;
      logic [COUNT_W-1:0] cnt;
      logic [TAG_W-1:0]   tag;
   } segment_desc_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [BYTES_W-1:0]    csr_data = '0;

   // Predicted receiver state
   logic [INDEX_W-1:0]    next_index;
   logic [BYTES_W-1:0]    bytes_in;
   logic [BYTES_W-1:0]    total_cfg;
   logic                  held [SLOTS];
   logic [COUNT_W-1:0]    held_count [SLOTS];
   logic [TAG_W-1:0]      held_tag [SLOTS];

   segment_desc_type      segment_q [$];
   rsp_item_type          due_results [$];
   segment_desc_type      offered;
   int                    segments_taken = 0;
   int                    mismatch_count = 0;
   int                    burst_left = 0;
   int                    gap_left = 0;
   logic                  hold_long = 1'b0;
   logic [15:0]           stall_bits;
   int                    stall_age;

   selective_repeat_reorder #(.WINDOW(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Print a mismatch line (for the first 50 only) and count every mismatch
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 50)
         $display("%0t ns result %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Add a segment's bytes to the accepted total, saturating at all ones
   function automatic logic [BYTES_W-1:0] bytes_plus(input logic [BYTES_W-1:0] acc,
                                                     input logic [COUNT_W-1:0] n);
      logic [BYTES_W:0] sum;
      sum = {1'b0, acc} + (BYTES_W+1)'(n);
      return sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
   endfunction

   // Advance the reorder window by one accepted segment and queue the results it owes
   task automatic advance_window(input segment_desc_type d);
      rsp_item_type       run [$];
      rsp_item_type       r;
      logic [INDEX_W-1:0] ofs;
      logic [COUNT_W-1:0] n;
      logic               drop;
      int                 s;
      n = (d.cnt > COUNT_W'(MAX_PAYLOAD)) ? COUNT_W'(MAX_PAYLOAD) : d.cnt;
      drop = 1'b0;
      if (d.seg < next_index) return;
      ofs = d.seg - next_index;
      if (ofs == 0) begin
         r = '0;
         r.kind = KIND_DELIVER;
         r.out_tag = d.tag;
         r.out_count = n;
         run.push_back(r);
         bytes_in = bytes_plus(bytes_in, n);
         next_index++;
         // release buffered successors while they run on in sequence
         for (int k = 0; k < SLOTS; k++) begin
            s = int'(next_index % SLOTS);
            if (!held[s]) break;
            r = '0;
            r.kind = KIND_DELIVER;
            r.out_tag = held_tag[s];
            r.out_count = held_count[s];
            run.push_back(r);
            bytes_in = bytes_plus(bytes_in, held_count[s]);
            held[s] = 1'b0;
            next_index++;
         end
      end else if (ofs < SLOTS) begin
         s = int'(d.seg % SLOTS);
         held[s] = 1'b1;
         held_count[s] = n;
         held_tag[s] = d.tag;
      end else begin
         drop = 1'b1;
      end
      r = '0;
      r.kind = KIND_ACK;
      r.dropped = drop;
      run.push_back(r);
      // stamp final index, done flag and last marker on every result of the run
      foreach (run[i]) begin
         r = run[i];
         r.ack_index = next_index;
         r.done_res = (bytes_in >= total_cfg);
         r.last = (i == run.size() - 1);
         due_results.push_back(r);
      end
   endtask

   task automatic add_segment(input logic [INDEX_W-1:0] seg, input logic [COUNT_W-1:0] cnt,
                              input logic [TAG_W-1:0] tag);
      segment_desc_type d;
      d.seg = seg;
      d.cnt = cnt;
      d.tag = tag;
      segment_q.push_back(d);
   endtask

   // Segment with random byte count (sometimes oversized) and random tag
   task automatic add_random_content(input logic [INDEX_W-1:0] seg);
      logic [COUNT_W-1:0] cnt;
      if ($urandom_range(0, 15) == 0)
         cnt = COUNT_W'($urandom_range(MAX_PAYLOAD + 1, 2047));
      else
         cnt = COUNT_W'($urandom_range(0, MAX_PAYLOAD));
      add_segment(seg, cnt, TAG_W'($urandom));
   endtask

   // Queue shuffled runs of consecutive indices, mixed with duplicates, stale and far segments
   task automatic queue_random_runs(input int goal);
      logic [INDEX_W-1:0] order [$];
      logic [INDEX_W-1:0] base;
      logic [INDEX_W-1:0] t;
      int                 made;
      int                 n;
      int                 j;
      base = next_index;
      made = 0;
      while (made < goal) begin
         n = ($urandom_range(0, 3) == 0) ? SLOTS : $urandom_range(1, SLOTS);
         order.delete();
         for (int i = 0; i < n; i++) order.push_back(base + i);
         for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
         end
         foreach (order[i]) begin
            add_random_content(order[i]);
            made++;
            case ($urandom_range(0, 15))
               0: begin
                  add_random_content(order[$urandom_range(0, i)]);
                  made++;
               end
               1: if (base > 0) add_random_content($urandom_range(0, base - 1));
               2: begin
                  add_random_content(base + 32 + $urandom_range(0, 4000));
                  made++;
               end
               3: begin
                  add_random_content($urandom);
                  made++;
               end
               default: ;
            endcase
         end
         base += n;
      end
   endtask

   // Wait until no segment is queued or in flight and no result is owed
   task automatic wait_idle();
      while (segment_q.size() != 0 || req_tvalid || due_results.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_total(input logic [BYTES_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      total_cfg = v;
   endtask

   // Driver: offer queued segments in bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_window(offered);
            segments_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 && !hold_long) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (segment_q.size() != 0) begin
               offered = segment_q.pop_front();
               req_tdata <= {5'b0, offered.tag, offered.cnt, offered.seg};
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                         : $urandom_range(0, 2);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transaction and stall on a rotating pattern
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_bits = '1;
         stall_age = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_mismatch("with nothing owed", rsp_tdata, '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("kind", rsp_tuser, want.kind);
               if (rsp_tdata[15:0] !== want.out_tag)
                  report_mismatch("out_tag", rsp_tdata[15:0], want.out_tag);
               if (rsp_tdata[26:16] !== want.out_count)
                  report_mismatch("out_count", rsp_tdata[26:16], want.out_count);
               if (rsp_tdata[58:27] !== want.ack_index)
                  report_mismatch("ack_index", rsp_tdata[58:27], want.ack_index);
               if (rsp_tdata[59] !== want.dropped)
                  report_mismatch("dropped", rsp_tdata[59], want.dropped);
               if (rsp_tdata[60] !== want.done_res)
                  report_mismatch("done_res", rsp_tdata[60], want.done_res);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", rsp_tlast, want.last);
            end
         end
         if (stall_age == 0) begin
            stall_age = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
               0: stall_bits = '1;
               1: stall_bits = 16'($urandom);
               2: stall_bits = 16'($urandom | $urandom);
               default: stall_bits = 16'($urandom & $urandom);
            endcase
            if (stall_bits == 0) stall_bits = 16'h0001;
         end
         stall_age--;
         stall_bits = {stall_bits[0], stall_bits[15:1]};
         rsp_tready <= stall_bits[0] && !hold_long;
      end
   end

   // Hold off the receiver for a long stretch so the block backs up into its input
   initial begin
      while (segments_taken < 140) @(posedge clock);
      hold_long <= 1'b1;
      repeat (400) @(posedge clock);
      hold_long <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("selective_repeat_reorder: mismatch");
      $finish;
   end

   initial begin
      next_index = '0;
      bytes_in = '0;
      total_cfg = '0;
      foreach (held[i]) begin
         held[i] = 1'b0;
         held_count[i] = '0;
         held_tag[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: zero total, so every result reports done
      wait_idle();
      write_total(32'h0);
      add_segment(32'd0, 11'd0, 16'h0000);
      add_segment(32'd0, 11'd17, 16'h0001);          // stale index, no result
      add_segment(32'd3, 11'd1024, 16'hFFFF);        // early, stored
      add_segment(32'd3, 11'd2047, 16'h1234);        // duplicate overwrite, oversized count
      add_segment(32'd2, 11'd5, 16'hAAAA);
      add_segment(32'd1, 11'd100, 16'h5555);         // releases 2 and 3
      add_segment(32'd20, 11'd1, 16'h0000);          // one past the window edge
      add_segment(32'd19, 11'd1, 16'h0001);          // last slot inside the window
      add_segment(32'hFFFF_FFFF, 11'd2047, 16'hFFFF); // far beyond the window
      for (int i = 5; i <= 18; i++)
         add_segment(i, 11'(i * 73), 16'(16'h8000 >> (i - 5)));
      add_segment(32'd4, 11'd1025, 16'h8000);        // releases the whole window

      // random phases under different totals
      wait_idle();
      write_total(32'hFFFF_FFFF);
      queue_random_runs(63);
      wait_idle();
      write_total(bytes_in + 32'd20000);
      queue_random_runs(63);
      wait_idle();
      write_total(bytes_in);
      queue_random_runs(63);
      wait_idle();
      write_total(bytes_in + 32'd30000);
      queue_random_runs(63);
      wait_idle();

      if (mismatch_count == 0)
         $display("selective_repeat_reorder: match");
      else
         $display("selective_repeat_reorder: mismatch");
      $finish;
   end

endmodule
